FILE: design/bwnf_pkg.sv
// ----------------------------------------------------------------------------
// Banned word name filter package
// Shared commands, entry kinds, controller states and the ASCII lower-case
// helper.
// ----------------------------------------------------------------------------
package bwnf_pkg;

    localparam int NUM_WORDS_DEF = 64;
    localparam int WORD_LEN_DEF  = 15;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        CMD_SET_ENTRY  = 2'd0,
        CMD_WRITE_CHAR = 2'd1,
        CMD_NAME_CHAR  = 2'd2,
        CMD_UNUSED     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_OFF     = 2'd0,
        KIND_EXACT   = 2'd1,
        KIND_SUBSTR  = 2'd2,
        KIND_OFF_ALT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } st_t;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

FILE: design/bwnf_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one character of the recent-name window, passes it to the next cell
// on every name beat and compares it with the word character that lines up
// with it for the entry being scanned.
// ----------------------------------------------------------------------------
module bwnf_cell #(
    parameter int WORD_LEN = 15,
    parameter int POS      = 0,
    localparam int LEN_W   = $clog2(WORD_LEN + 1),
    localparam int POS_W   = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic                         clear,
    input  logic [7:0]                   char_in,
    output logic [7:0]                   char_out,
    input  logic [LEN_W-1:0]             word_len,
    input  logic [WORD_LEN-1:0][7:0]     word_row,
    output logic                         match
);

    logic [7:0]  win_reg;
    logic [7:0]  win_next;
    logic [31:0] sel32;

    always_comb
    begin
        win_next = win_reg;
        if (clear)
        begin
            win_next = 8'd0;
        end
        else if (shift_en)
        begin
            win_next = char_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= 8'd0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    // Window slot POS holds the newest-minus-POS character, which lines up
    // with word position len-1-POS.
    always_comb
    begin
        sel32 = 32'(word_len) - 32'(POS) - 32'd1;
        if (32'(POS) < 32'(word_len))
        begin
            match = (win_reg == word_row[sel32[POS_W-1:0]]);
        end
        else
        begin
            match = 1'b1;
        end
    end

    assign char_out = win_reg;

endmodule

FILE: design/bwnf_table.sv
// ----------------------------------------------------------------------------
// Banned word table
// Entry kind and length memory plus a word memory with one row of characters
// per entry, written one byte at a time and read a whole row per cycle.
// ----------------------------------------------------------------------------
module bwnf_table #(
    parameter int NUM_WORDS = 64,
    parameter int WORD_LEN  = 15,
    localparam int IDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
    localparam int LEN_W    = $clog2(WORD_LEN + 1),
    localparam int POS_W    = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1
) (
    input  logic                      clk,
    input  logic                      ent_we,
    input  logic [IDX_W-1:0]          ent_addr,
    input  bwnf_pkg::kind_t           ent_kind,
    input  logic [LEN_W-1:0]          ent_len,
    input  logic                      chr_we,
    input  logic [IDX_W-1:0]          chr_addr,
    input  logic [POS_W-1:0]          chr_pos,
    input  logic [7:0]                chr_value,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output bwnf_pkg::kind_t           rd_kind,
    output logic [LEN_W-1:0]          rd_len,
    output logic [WORD_LEN-1:0][7:0]  rd_row
);

    import bwnf_pkg::*;

    kind_t                    kind_mem [NUM_WORDS];
    logic [LEN_W-1:0]         len_mem  [NUM_WORDS];
    logic [WORD_LEN-1:0][7:0] row_mem  [NUM_WORDS];

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            kind_mem[ent_addr] <= ent_kind;
            len_mem[ent_addr]  <= ent_len;
        end
        if (rd_en)
        begin
            rd_kind <= kind_mem[rd_addr];
            rd_len  <= len_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (chr_we)
        begin
            row_mem[chr_addr][chr_pos] <= chr_value;
        end
        if (rd_en)
        begin
            rd_row <= row_mem[rd_addr];
        end
    end

endmodule

FILE: design/banned_word_name_filter.sv
// ----------------------------------------------------------------------------
// Banned word name filter
// Case-insensitive match of a streamed name against a table of banned words.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis; tuser carries the command. A set-entry beat
// writes an entry's kind and length, a write-char beat stores one word
// character, and a name-char beat shifts one lower-cased byte into a row of
// window cells. Set-entry and write-char beats leave the block ready for the next beat.
// A name-char beat starts a scan of the table, one entry per cycle from the
// word memory read port, and the block takes no further beat until the
// scan, a tail step and a done step are through. On a beat with tlast set,
// the pass/fail result (tdata bit 0, 1 = allowed) is loaded into the output
// register in the done step once that register is free, and the window,
// length count, substring flag and exact flag then clear.
// After reset a clearing pass over the table turns every entry off;
// s_axis_tready stays low during it. Word characters are not cleared.
// A result waits in the output register while m_axis_tready is low and the
// block keeps taking beats; only the closing step of a further name waits
// for the register to empty.
// ----------------------------------------------------------------------------
module banned_word_name_filter #(
    parameter int NUM_WORDS = bwnf_pkg::NUM_WORDS_DEF,
    parameter int WORD_LEN  = bwnf_pkg::WORD_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // entry_index[5:0], entry_type[7:6], word_length[11:8],
    // char_position[15:12], char_value[23:16]
    input  logic [bwnf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command[1:0]
    input  logic [bwnf_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // name_allowed[0], zero fill [7:1]
    output logic [bwnf_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import bwnf_pkg::*;

    localparam int IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LEN_W = $clog2(WORD_LEN + 1);
    localparam int POS_W = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;
    localparam int CNT_W = $clog2(WORD_LEN + 2);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NUM_WORDS - 1);

    // Field unpacking
    cmd_t        cmd;
    logic [5:0]  entry_index;
    kind_t       entry_type;
    logic [3:0]  word_length;
    logic [3:0]  char_position;
    logic [7:0]  char_value;

    assign cmd           = cmd_t'(s_axis_tuser);
    assign entry_index   = s_axis_tdata[5:0];
    assign entry_type    = kind_t'(s_axis_tdata[7:6]);
    assign word_length   = s_axis_tdata[11:8];
    assign char_position = s_axis_tdata[15:12];
    assign char_value    = s_axis_tdata[23:16];

    st_t              state_reg, state_next;
    logic [IDX_W-1:0] scan_addr_reg, scan_addr_next;
    logic             pend_reg;
    logic             last_name_reg, last_name_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             banned_reg, banned_next;
    logic             exact_reg, exact_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_allowed_reg, out_allowed_next;

    logic             accept;
    logic             idx_ok;
    logic             pos_ok;
    logic [31:0]      idx32;
    logic [31:0]      pos32;
    logic [31:0]      len32;
    logic [IDX_W-1:0] idx_addr;
    logic [LEN_W-1:0] sat_len;

    logic             ent_we;
    logic [IDX_W-1:0] ent_addr;
    kind_t            ent_kind;
    logic [LEN_W-1:0] ent_len;
    logic             chr_we;
    logic             rd_en;
    kind_t            rd_kind;
    logic [LEN_W-1:0] rd_len;
    logic [WORD_LEN-1:0][7:0] rd_row;

    logic             shift_en;
    logic             clear_name;
    logic [7:0]       chain [WORD_LEN+1];
    logic [WORD_LEN-1:0] cell_match;
    logic             win_match;
    logic             sub_hit;
    logic             exact_hit;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign idx32  = 32'(entry_index);
    assign pos32  = 32'(char_position);
    assign idx_ok = idx32 < 32'(NUM_WORDS);
    assign pos_ok = pos32 < 32'(WORD_LEN);
    assign idx_addr = idx32[IDX_W-1:0];
    assign len32  = (32'(word_length) > 32'(WORD_LEN)) ? 32'(WORD_LEN) : 32'(word_length);
    assign sat_len = len32[LEN_W-1:0];

    // The clearing pass borrows the entry write port.
    assign ent_we   = (state_reg == ST_CLEAR) ||
                      (accept && cmd == CMD_SET_ENTRY && idx_ok);
    assign ent_addr = (state_reg == ST_CLEAR) ? scan_addr_reg : idx_addr;
    assign ent_kind = (state_reg == ST_CLEAR) ? KIND_OFF : entry_type;
    assign ent_len  = (state_reg == ST_CLEAR) ? '0 : sat_len;
    assign chr_we   = accept && cmd == CMD_WRITE_CHAR && idx_ok && pos_ok;
    assign rd_en    = (state_reg == ST_SCAN);
    assign shift_en = accept && cmd == CMD_NAME_CHAR;

    bwnf_table #(
        .NUM_WORDS (NUM_WORDS),
        .WORD_LEN  (WORD_LEN)
    ) u_table (
        .clk       (clk),
        .ent_we    (ent_we),
        .ent_addr  (ent_addr),
        .ent_kind  (ent_kind),
        .ent_len   (ent_len),
        .chr_we    (chr_we),
        .chr_addr  (idx_addr),
        .chr_pos   (pos32[POS_W-1:0]),
        .chr_value (lower_byte(char_value)),
        .rd_en     (rd_en),
        .rd_addr   (scan_addr_reg),
        .rd_kind   (rd_kind),
        .rd_len    (rd_len),
        .rd_row    (rd_row)
    );

    assign chain[0] = lower_byte(char_value);

    for (genvar j = 0; j < WORD_LEN; j++)
    begin : g_cell
        bwnf_cell #(
            .WORD_LEN (WORD_LEN),
            .POS      (j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .clear    (clear_name),
            .char_in  (chain[j]),
            .char_out (chain[j+1]),
            .word_len (rd_len),
            .word_row (rd_row),
            .match    (cell_match[j])
        );
    end

    // The count and window already include the beat that started the scan.
    assign win_match = (&cell_match) && (32'(count_reg) >= 32'(rd_len));
    assign sub_hit   = pend_reg && rd_kind == KIND_SUBSTR && win_match;
    assign exact_hit = pend_reg && last_name_reg && rd_kind == KIND_EXACT &&
                       (32'(count_reg) == 32'(rd_len)) && win_match;

    always_comb
    begin
        state_next       = state_reg;
        scan_addr_next   = scan_addr_reg;
        last_name_next   = last_name_reg;
        count_next       = count_reg;
        banned_next      = banned_reg || sub_hit;
        exact_next       = exact_reg || exact_hit;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_allowed_next = out_allowed_reg;
        clear_name       = 1'b0;
        s_axis_tready    = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                if (scan_addr_reg == LAST_ADDR)
                begin
                    scan_addr_next = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (shift_en)
                begin
                    last_name_next = s_axis_tlast;
                    if (32'(count_reg) < 32'(WORD_LEN + 1))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_addr_reg == LAST_ADDR)
                begin
                    scan_addr_next = '0;
                    state_next     = ST_TAIL;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!last_name_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_allowed_next = !(banned_reg || exact_reg);
                    clear_name       = 1'b1;
                    count_next       = '0;
                    banned_next      = 1'b0;
                    exact_next       = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            scan_addr_reg <= '0;
            pend_reg      <= 1'b0;
            last_name_reg <= 1'b0;
            count_reg     <= '0;
            banned_reg    <= 1'b0;
            exact_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_addr_reg <= scan_addr_next;
            pend_reg      <= rd_en;
            last_name_reg <= last_name_next;
            count_reg     <= count_next;
            banned_reg    <= banned_next;
            exact_reg     <= exact_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_allowed_reg <= out_allowed_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_allowed_reg};

endmodule

FILE: design/bwnf_checker.sv
// ----------------------------------------------------------------------------
// Banned word name filter checker
// Port-level assertions on handshake timing, bound to the top level.
// ----------------------------------------------------------------------------
module bwnf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [bwnf_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bwnf_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import bwnf_pkg::*;

    // A name beat always starts a table scan, so the next beat must wait.
    a_name_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_NAME_CHAR)
        |=> !s_axis_tready)
        else $error("name beat accepted without starting a scan");

    // Table loading beats never produce a result.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != CMD_NAME_CHAR)
        |=> !$rose(m_axis_tvalid))
        else $error("result raised after a table loading beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

endmodule

bind banned_word_name_filter bwnf_checker u_bwnf_checker (.*);

FILE: tb/banned_word_name_filter_tb.sv
// ----------------------------------------------------------------------------
// Banned word name filter testbench
// Loads banned words through the input stream and streams names against
// them. A behavioral copy of the word table, the character window and the
// substring flag predicts each verdict. A scoreboard compares every output
// beat with the oldest predicted verdict. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module banned_word_name_filter_tb;

    import bwnf_pkg::*;

    localparam int NUM_WORDS  = NUM_WORDS_DEF;
    localparam int WORD_LEN   = WORD_LEN_DEF;
    localparam int ITEM_GOAL  = 500;
    localparam int QUIET_MAX  = 4000;
    localparam int DRAIN      = 4 * (NUM_WORDS + 3);
    localparam int CALM_START = 3000;
    localparam int CALM_END   = 9000;

    typedef struct {
        cmd_t       command;
        logic [5:0] entry_index;
        kind_t      entry_type;
        logic [3:0] word_length;
        logic [3:0] char_position;
        logic [7:0] char_value;
        logic       last;
    } filter_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    filter_beat_t pending_beats[$];
    filter_beat_t beat_on_bus;
    logic         verdict_q[$];
    int           errors = 0;
    int           quiet_cycles = 0;
    int           cycle_count = 0;

    // Predicted block state.
    logic [7:0] tb_chars[NUM_WORDS][WORD_LEN];
    kind_t      tb_kind[NUM_WORDS];
    logic [3:0] tb_len[NUM_WORDS];
    logic [7:0] tb_window[WORD_LEN];
    int         tb_count;
    bit         tb_banned;

    // Table contents as the stimulus generator sees them at generation time.
    kind_t      gen_kind[NUM_WORDS];
    int         gen_len[NUM_WORDS];
    logic [7:0] gen_chars[NUM_WORDS][WORD_LEN];
    bit         gen_written[NUM_WORDS][WORD_LEN];
    logic [7:0] name_buf[$];
    int         gen_items = 0;

    banned_word_name_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit take_break();
        if (cycle_count >= CALM_START && cycle_count < CALM_END)
        begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 35;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            return c | 8'h20;
        end
        return c;
    endfunction

    // True when the newest n window bytes spell the word of entry e.
    function automatic bit tail_matches(input int e, input int n);
        if (tb_count < n)
        begin
            return 1'b0;
        end
        for (int k = 0; k < n; k++)
        begin
            if (tb_window[n - 1 - k] != fold_case(tb_chars[e][k]))
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic screen_name_beat(input filter_beat_t b);
        bit exact_hit;
        exact_hit = 1'b0;
        case (b.command)
            CMD_SET_ENTRY:
            begin
                tb_kind[b.entry_index] = b.entry_type;
                tb_len[b.entry_index]  = (b.word_length > WORD_LEN) ? 4'(WORD_LEN)
                                                                     : b.word_length;
            end
            CMD_WRITE_CHAR:
            begin
                if (b.char_position < WORD_LEN)
                begin
                    tb_chars[b.entry_index][b.char_position] = b.char_value;
                end
            end
            CMD_NAME_CHAR:
            begin
                for (int k = WORD_LEN - 1; k > 0; k--)
                begin
                    tb_window[k] = tb_window[k - 1];
                end
                tb_window[0] = fold_case(b.char_value);
                if (tb_count < WORD_LEN + 1)
                begin
                    tb_count++;
                end
                for (int e = 0; e < NUM_WORDS; e++)
                begin
                    if (tb_kind[e] == KIND_SUBSTR)
                    begin
                        if (tail_matches(e, tb_len[e]))
                        begin
                            tb_banned = 1'b1;
                        end
                    end
                    else if (tb_kind[e] == KIND_EXACT && b.last)
                    begin
                        if (tb_count == tb_len[e] && tail_matches(e, tb_len[e]))
                        begin
                            exact_hit = 1'b1;
                        end
                    end
                end
                if (b.last)
                begin
                    verdict_q.push_back(!(tb_banned || exact_hit));
                    for (int k = 0; k < WORD_LEN; k++)
                    begin
                        tb_window[k] = 8'h00;
                    end
                    tb_count  = 0;
                    tb_banned = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Driver: a new beat is offered only once the previous one was taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                screen_name_beat(beat_on_bus);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_beats.size() != 0 && !take_break())
                begin
                    beat_on_bus = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= beat_on_bus.command;
                    s_axis_tlast  <= beat_on_bus.last;
                    s_axis_tdata  <= {beat_on_bus.char_value, beat_on_bus.char_position,
                                      beat_on_bus.word_length, beat_on_bus.entry_type,
                                      beat_on_bus.entry_index};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            m_axis_tready <= !take_break();
        end
    end

    // Monitor and stall counter.
    always @(posedge clk)
    begin : monitor
        logic [M_TDATA_W-1:0] want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected verdict beat, actual %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = {7'b0, verdict_q.pop_front()};
                    if (m_axis_tdata !== want)
                    begin
                        $display("%0t: verdict mismatch, expected %h actual %h",
                                 $time, want, m_axis_tdata);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic queue_beat(input cmd_t cmd, input int idx, input int kind, input int len,
                              input int pos, input int val, input bit lst);
        filter_beat_t b;
        b.command       = cmd;
        b.entry_index   = idx[5:0];
        b.entry_type    = kind_t'(kind[1:0]);
        b.word_length   = len[3:0];
        b.char_position = pos[3:0];
        b.char_value    = val[7:0];
        b.last          = lst;
        pending_beats.push_back(b);
        if (cmd != CMD_UNUSED)
        begin
            gen_items++;
        end
    endtask

    task automatic load_entry(input int idx, input kind_t kind, input int len);
        queue_beat(CMD_SET_ENTRY, idx, kind, len, $urandom_range(0, 15),
                   $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        gen_kind[idx] = kind;
        gen_len[idx]  = len;
    endtask

    task automatic load_char(input int idx, input int pos, input int val);
        queue_beat(CMD_WRITE_CHAR, idx, $urandom_range(0, 3), $urandom_range(0, 15),
                   pos, val, 1'($urandom_range(0, 1)));
        if (pos < WORD_LEN)
        begin
            gen_chars[idx][pos]   = val[7:0];
            gen_written[idx][pos] = 1'b1;
        end
    endtask

    task automatic send_name();
        for (int i = 0; i < name_buf.size(); i++)
        begin
            queue_beat(CMD_NAME_CHAR, $urandom_range(0, 63), $urandom_range(0, 3),
                       $urandom_range(0, 15), $urandom_range(0, 15), name_buf[i],
                       i == name_buf.size() - 1);
        end
        name_buf.delete();
    endtask

    function automatic logic [7:0] letter_byte();
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
    endfunction

    function automatic int word_byte();
        return ($urandom_range(0, 99) < 80) ? letter_byte() : $urandom_range(0, 255);
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (fold_case(c) >= 8'h61 && fold_case(c) <= 8'h7a && $urandom_range(0, 1))
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // Every position an enabled word can reach is written before the kind is set.
    task automatic define_word(input int idx, input kind_t kind, input int len);
        for (int k = 0; k < len; k++)
        begin
            if (!gen_written[idx][k] || $urandom_range(0, 2) == 0)
            begin
                load_char(idx, k, word_byte());
            end
        end
        load_entry(idx, kind, len);
    endtask

    initial
    begin : stimulus
        int    idx;
        int    len;
        int    roll;
        int    pick;
        int    pre;
        int    post;
        kind_t kind;
        int    live_idx[$];
        for (int e = 0; e < NUM_WORDS; e++)
        begin
            gen_kind[e] = KIND_OFF;
            gen_len[e]  = 0;
            tb_kind[e]  = KIND_OFF;
            tb_len[e]   = 4'd0;
            for (int k = 0; k < WORD_LEN; k++)
            begin
                gen_written[e][k] = 1'b0;
            end
        end
        for (int k = 0; k < WORD_LEN; k++)
        begin
            tb_window[k] = 8'h00;
        end

        // Directed part.
        queue_beat(CMD_UNUSED, 63, 3, 15, 15, 255, 1'b1);
        name_buf = '{8'h00, 8'hff};
        send_name();
        load_char(63, 0, "A");
        load_char(63, 1, "b");
        load_char(63, 15, 8'hff);
        load_entry(63, KIND_SUBSTR, 2);
        name_buf = '{"x", "a", "B", "y"};
        send_name();
        load_entry(63, KIND_OFF_ALT, 2);
        name_buf = '{"a", "b"};
        send_name();
        load_char(0, 0, "Z");
        load_char(0, 1, "[");
        load_entry(0, KIND_EXACT, 2);
        name_buf = '{"z", "["};
        send_name();
        name_buf = '{"x", "z", "["};
        send_name();
        // An empty substring word bans any name; an empty exact word bans none.
        load_entry(1, KIND_SUBSTR, 0);
        name_buf = '{"q"};
        send_name();
        load_entry(1, KIND_OFF, 0);
        load_entry(2, KIND_EXACT, 0);
        name_buf = '{"q"};
        send_name();
        load_entry(2, KIND_OFF, 0);
        // Bytes above 0x7f are not folded.
        load_char(3, 0, 8'hc1);
        load_entry(3, KIND_SUBSTR, 1);
        name_buf = '{8'he1};
        send_name();
        load_entry(3, KIND_OFF, 1);

        // Random part.
        while (gen_items < ITEM_GOAL)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 14)
            begin
                idx  = $urandom_range(0, NUM_WORDS - 1);
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    kind = KIND_OFF;
                else if (pick < 45)
                    kind = KIND_OFF_ALT;
                else if (pick < 75)
                    kind = KIND_EXACT;
                else
                    kind = KIND_SUBSTR;
                pick = $urandom_range(0, 99);
                if (pick < 4 && kind != KIND_SUBSTR)
                    len = 0;
                else if (pick < 9)
                    len = 1;
                else if (pick < 16)
                    len = WORD_LEN;
                else if (pick < 24)
                    len = $urandom_range(7, WORD_LEN - 1);
                else
                    len = $urandom_range(2, 6);
                define_word(idx, kind, len);
            end
            else if (roll < 16)
            begin
                // A short burst with an empty substring word, switched off again.
                idx = $urandom_range(0, NUM_WORDS - 1);
                load_entry(idx, KIND_SUBSTR, 0);
                repeat ($urandom_range(1, 4)) name_buf.push_back(letter_byte());
                send_name();
                load_entry(idx, KIND_OFF, 0);
            end
            else if (roll < 22)
            begin
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    queue_beat(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 3),
                               $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 255), 1'($urandom_range(0, 1)));
                else if (pick == 1)
                    load_char($urandom_range(0, NUM_WORDS - 1), 15, $urandom_range(0, 255));
                else
                    load_char($urandom_range(0, NUM_WORDS - 1),
                              $urandom_range(0, WORD_LEN - 1), word_byte());
            end
            else
            begin
                live_idx.delete();
                for (int e = 0; e < NUM_WORDS; e++)
                begin
                    if ((gen_kind[e] == KIND_EXACT || gen_kind[e] == KIND_SUBSTR) &&
                        gen_len[e] > 0)
                    begin
                        live_idx.push_back(e);
                    end
                end
                pick = $urandom_range(0, 99);
                if (pick < 50 && live_idx.size() != 0)
                begin
                    idx = live_idx[$urandom_range(0, live_idx.size() - 1)];
                    if (gen_kind[idx] == KIND_EXACT && $urandom_range(0, 3) != 0)
                    begin
                        pre  = 0;
                        post = 0;
                    end
                    else
                    begin
                        pre  = $urandom_range(0, 4);
                        post = $urandom_range(0, 4);
                    end
                    repeat (pre) name_buf.push_back(letter_byte());
                    for (int k = 0; k < gen_len[idx]; k++)
                    begin
                        name_buf.push_back(flip_case(gen_chars[idx][k]));
                    end
                    repeat (post) name_buf.push_back(letter_byte());
                    // Now and then spoil one character for a near miss.
                    if ($urandom_range(0, 4) == 0)
                    begin
                        name_buf[$urandom_range(0, name_buf.size() - 1)] = letter_byte();
                    end
                end
                else if (pick < 75)
                begin
                    repeat ($urandom_range(1, 8)) name_buf.push_back(letter_byte());
                end
                else if (pick < 87)
                begin
                    repeat ($urandom_range(WORD_LEN - 1, WORD_LEN + 5))
                        name_buf.push_back(letter_byte());
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                        name_buf.push_back(8'($urandom_range(0, 255)));
                end
                send_name();
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (!(pending_beats.size() == 0 && !s_axis_tvalid && verdict_q.size() == 0) &&
               quiet_cycles < QUIET_MAX)
        begin
            @(negedge clk);
        end
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("%0t: no progress, %0d verdicts outstanding", $time, verdict_q.size());
            $display("[banned_word_name_filter] ERROR");
        end
        else
        begin
            repeat (DRAIN) @(negedge clk);
            if (verdict_q.size() != 0)
            begin
                $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
                errors++;
            end
            if (errors == 0)
            begin
                $display("[banned_word_name_filter] OK");
            end
            else
            begin
                $display("[banned_word_name_filter] ERROR");
            end
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/bwnf_pkg.sv
design/bwnf_cell.sv
design/bwnf_table.sv
design/banned_word_name_filter.sv
design/bwnf_checker.sv
tb/banned_word_name_filter_tb.sv
